[hw/rtl/tree_q_learning_step_defines.svh]
// Assertion macros shared by the tree Q-learning step block.
`ifndef TREE_Q_LEARNING_STEP_DEFINES_SVH
`define TREE_Q_LEARNING_STEP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define TQLS_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tqls: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define TQLS_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tqls: next-cycle check failed");

`endif

[hw/rtl/tqls_pkg.sv]
// Package of the tree Q-learning step block: widths, register indexes and reset values.
`default_nettype none
package tqls_pkg;

  // Default structural sizes.
  localparam int NODES_DEF      = 15;
  localparam int LEVELS_DEF     = 3;
  localparam int VALUE_BITS_DEF = 10;

  // Fixed widths of the ports.
  localparam int NODE_W     = 4;
  localparam int VAL_W      = 10;
  localparam int CHANCE_W   = 8;
  localparam int COEF_W     = 8;
  localparam int EPS_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Operation codes of a request.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA        = 3'd0,
    CFG_GAMMA        = 3'd1,
    CFG_EPSILON      = 3'd2,
    CFG_GOAL_NODE    = 3'd3,
    CFG_GOAL_REWARD  = 3'd4,
    CFG_BONUS_NODE   = 3'd5,
    CFG_BONUS_REWARD = 3'd6
  } cfg_reg_e;

  // Register values after reset.
  localparam logic [COEF_W-1:0] ALPHA_RST        = 8'd26;
  localparam logic [COEF_W-1:0] GAMMA_RST        = 8'd230;
  localparam logic [EPS_W-1:0]  EPSILON_RST      = 9'd77;
  localparam logic [NODE_W-1:0] GOAL_NODE_RST    = 4'd14;
  localparam logic [VAL_W-1:0]  GOAL_REWARD_RST  = 10'd1000;
  localparam logic [NODE_W-1:0] BONUS_NODE_RST   = 4'd11;
  localparam logic [VAL_W-1:0]  BONUS_REWARD_RST = 10'd500;

endpackage
`default_nettype wire

[hw/rtl/tqls_qmem.sv]
// Q-table memory: one write port and one registered read port, out-of-range reads give zero.
`default_nettype none
module tqls_qmem import tqls_pkg::*; #(
  parameter int NODES      = NODES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int AW         = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [VALUE_BITS-1:0] wdata_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [VALUE_BITS-1:0] rdata_o
);

  localparam int MW = $clog2(NODES);

  logic [VALUE_BITS-1:0] mem_q [NODES];
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  rok_q;
  logic                  wr_ok;
  logic                  rd_ok;

  assign wr_ok = 32'(waddr_i) < NODES;
  assign rd_ok = 32'(raddr_i) < NODES;

  always_ff @(posedge clk_i) begin
    if (we_i && wr_ok) begin
      mem_q[waddr_i[MW-1:0]] <= wdata_i;
    end
    if (rd_ok) begin
      rdata_q <= mem_q[raddr_i[MW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rok_q <= 1'b0;
    end else begin
      rok_q <= rd_ok;
    end
  end

  assign rdata_o = rok_q ? rdata_q : '0;

endmodule
`default_nettype wire

[hw/rtl/tqls_mul.sv]
// Shared multiplier: an unsigned Q0.8 coefficient times a signed operand, product registered.
`default_nettype none
module tqls_mul import tqls_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic        [COEF_W-1:0]       coef_i,
  input  wire logic signed [VALUE_BITS:0]     opnd_i,
  output logic      signed [VALUE_BITS+9:0]   prod_o
);

  localparam int PW = VALUE_BITS + 10;

  logic signed [PW-1:0] prod_c;
  logic signed [PW-1:0] prod_q;

  assign prod_c = PW'($signed({1'b0, coef_i})) * PW'(opnd_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_c;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

[hw/rtl/tree_q_learning_step.sv]
// Top level of the tree Q-learning step block: sequencer, registers and result stage.
//
//   channel   direction  handshake                       payload
//   request   in         start high while busy low       op_i entry_index_i entry_value_i
//                                                        chance_i coin_i
//   result    out        done_o high for one cycle       node_o new_value_o explored_o
//                                                        episode_done_o
//   config    in         cfg_valid_i and cfg_ready_o     cfg_index_i cfg_data_i
//
// A load shows its result in the cycle after it is taken and never raises busy.
// A step runs S_RDR, S_CHOOSE and S_WB for a leaf without reward, adds S_DELTA for a
// rewarded leaf and S_RDB, S_MAX, S_DELTA for an inner node, set by the one read port
// of the Q-table and one multiplier shared by the discount and learning-rate product.
// A new request is taken in the cycle its predecessor's result is shown.
// Reset clears the current node to the root and the registers to their defaults; the
// Q-table holds nothing defined until it is loaded. The receiver cannot stall results.
`default_nettype none
`include "tree_q_learning_step_defines.svh"
module tree_q_learning_step import tqls_pkg::*; #(
  parameter int NODES      = NODES_DEF,
  parameter int LEVELS     = LEVELS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  op_i,
  input  wire logic [NODE_W-1:0]     entry_index_i,
  input  wire logic [VAL_W-1:0]      entry_value_i,
  input  wire logic [CHANCE_W-1:0]   chance_i,
  input  wire logic                  coin_i,
  output logic                       done_o,
  output logic      [NODE_W-1:0]     node_o,
  output logic      [VAL_W-1:0]      new_value_o,
  output logic                       explored_o,
  output logic                       episode_done_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int VB    = VALUE_BITS;
  localparam int INNER = (1 << LEVELS) - 1;
  localparam int CH_W  = LEVELS + 1;
  localparam int IDX_W = LEVELS + 2;
  localparam int MW    = $clog2(NODES);
  localparam int AW0   = (IDX_W > NODE_W) ? IDX_W : NODE_W;
  localparam int AW    = (AW0 > MW) ? AW0 : MW;
  localparam int PW    = VB + 10;
  localparam int SW    = VB + 3;
  localparam logic [VB-1:0] VMAX = '1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDR    = 7'b0000010,
    S_CHOOSE = 7'b0000100,
    S_RDB    = 7'b0001000,
    S_MAX    = 7'b0010000,
    S_DELTA  = 7'b0100000,
    S_WB     = 7'b1000000
  } state_e;

  function automatic logic [VB-1:0] sat_in(input logic [VAL_W-1:0] v);
    logic [VB-1:0] r;
    if (32'(v) > 32'(VMAX)) begin
      r = VMAX;
    end else begin
      r = VB'(v);
    end
    return r;
  endfunction

  state_e state_q, state_d;

  // Configuration registers.
  logic [COEF_W-1:0] alpha_q, gamma_q;
  logic [EPS_W-1:0]  eps_q;
  logic [NODE_W-1:0] goal_node_q, bonus_node_q;
  logic [VAL_W-1:0]  goal_rew_q, bonus_rew_q;

  // Walk state and working registers.
  logic [LEVELS-1:0] cur_q;
  logic              explore_q, coin_q, leaf_q, keep_q;
  logic [CH_W-1:0]   chosen_q;
  logic [VB-1:0]     a_q, q_q, tgt_q;

  // Result stage.
  logic              done_q, explored_q, episode_q;
  logic [NODE_W-1:0] node_q;
  logic [VAL_W-1:0]  value_q;

  logic                  accept;
  logic [CH_W-1:0]       left_c, right_c, chosen_c;
  logic                  right_pick_c, leaf_c, goal_hit_c, bonus_hit_c;
  logic [VB-1:0]         rdata, qc_c, qmax_c, tgt_c, load_val_c, nv_c;
  logic [AW-1:0]         raddr, waddr;
  logic [VB-1:0]         wdata;
  logic                  we;
  logic                  mul_en;
  logic [COEF_W-1:0]     mul_coef;
  logic signed [VB:0]    mul_opnd, delta_c;
  logic signed [PW-1:0]  prod;
  logic signed [VB+1:0]  step_c;
  logic signed [SW-1:0]  sum_c;
  logic                  chosen_ok_c, load_ok_c;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign left_c  = {cur_q, 1'b1};
  assign right_c = left_c + CH_W'(1);

  // Greedy choice keeps the left child only when it is strictly better.
  assign right_pick_c = explore_q ? coin_q : !(a_q > rdata);
  assign chosen_c     = right_pick_c ? right_c : left_c;
  assign qc_c         = right_pick_c ? rdata : a_q;
  assign leaf_c       = 32'(chosen_c) >= INNER;
  assign goal_hit_c   = 32'(chosen_c) == 32'(goal_node_q);
  assign bonus_hit_c  = 32'(chosen_c) == 32'(bonus_node_q);

  assign qmax_c  = (a_q > rdata) ? a_q : rdata;
  assign tgt_c   = leaf_q ? tgt_q : prod[VB+7:8];
  assign delta_c = $signed({1'b0, tgt_c}) - $signed({1'b0, q_q});

  // Arithmetic shift of the product floors toward minus infinity.
  assign step_c = prod[PW-1:8];
  assign sum_c  = $signed({3'b000, q_q}) + SW'(step_c);

  always_comb begin
    if (keep_q) begin
      nv_c = q_q;
    end else if (sum_c < 0) begin
      nv_c = '0;
    end else if (sum_c > $signed({3'b000, VMAX})) begin
      nv_c = VMAX;
    end else begin
      nv_c = VB'(sum_c);
    end
  end

  assign load_val_c  = sat_in(entry_value_i);
  assign load_ok_c   = 32'(entry_index_i) < NODES;
  assign chosen_ok_c = 32'(chosen_q) < NODES;

  always_comb begin
    raddr = '0;
    unique case (state_q)
      S_IDLE:   raddr = AW'(left_c);
      S_RDR:    raddr = AW'(right_c);
      S_CHOOSE: raddr = AW'({chosen_c, 1'b1});
      S_RDB:    raddr = AW'({chosen_q, 1'b1}) + AW'(1);
      default:  raddr = '0;
    endcase
  end

  assign we    = (accept && (op_i == OP_LOAD)) || (state_q == S_WB);
  assign waddr = (state_q == S_WB) ? AW'(chosen_q) : AW'(entry_index_i);
  assign wdata = (state_q == S_WB) ? nv_c : load_val_c;

  assign mul_en   = (state_q == S_MAX) || (state_q == S_DELTA);
  assign mul_coef = (state_q == S_MAX) ? gamma_q : alpha_q;
  assign mul_opnd = (state_q == S_MAX) ? $signed({1'b0, qmax_c}) : delta_c;

  tqls_qmem #(
    .NODES      (NODES),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_qmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tqls_mul #(
    .VALUE_BITS (VALUE_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .coef_i (mul_coef),
    .opnd_i (mul_opnd),
    .prod_o (prod)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (op_i == OP_STEP)) begin
          state_d = S_RDR;
        end
      end
      S_RDR: state_d = S_CHOOSE;
      S_CHOOSE: begin
        if (!leaf_c) begin
          state_d = S_RDB;
        end else if (goal_hit_c || bonus_hit_c) begin
          state_d = S_DELTA;
        end else begin
          state_d = S_WB;
        end
      end
      S_RDB:   state_d = S_MAX;
      S_MAX:   state_d = S_DELTA;
      S_DELTA: state_d = S_WB;
      S_WB:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      done_q       <= 1'b0;
      alpha_q      <= ALPHA_RST;
      gamma_q      <= GAMMA_RST;
      eps_q        <= EPSILON_RST;
      goal_node_q  <= GOAL_NODE_RST;
      goal_rew_q   <= GOAL_REWARD_RST;
      bonus_node_q <= BONUS_NODE_RST;
      bonus_rew_q  <= BONUS_REWARD_RST;
    end else begin
      state_q <= state_d;
      done_q  <= (accept && (op_i == OP_LOAD)) || (state_q == S_WB);
      if ((state_q == S_WB) && leaf_q) begin
        cur_q <= '0;
      end else if (state_q == S_WB) begin
        cur_q <= chosen_q[LEVELS-1:0];
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ALPHA:        alpha_q      <= cfg_data_i[COEF_W-1:0];
          CFG_GAMMA:        gamma_q      <= cfg_data_i[COEF_W-1:0];
          CFG_EPSILON:      eps_q        <= cfg_data_i[EPS_W-1:0];
          CFG_GOAL_NODE:    goal_node_q  <= cfg_data_i[NODE_W-1:0];
          CFG_GOAL_REWARD:  goal_rew_q   <= cfg_data_i;
          CFG_BONUS_NODE:   bonus_node_q <= cfg_data_i[NODE_W-1:0];
          CFG_BONUS_REWARD: bonus_rew_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Working registers carry payload only and need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      explore_q <= {1'b0, chance_i} < eps_q;
      coin_q    <= coin_i;
    end
    if (state_q == S_RDR || state_q == S_RDB) begin
      a_q <= rdata;
    end
    if (state_q == S_CHOOSE) begin
      chosen_q <= chosen_c;
      q_q      <= qc_c;
      leaf_q   <= leaf_c;
      keep_q   <= leaf_c && !goal_hit_c && !bonus_hit_c;
      tgt_q    <= goal_hit_c ? sat_in(goal_rew_q) : sat_in(bonus_rew_q);
    end
    if (accept && (op_i == OP_LOAD)) begin
      node_q     <= entry_index_i;
      value_q    <= load_ok_c ? VAL_W'(load_val_c) : '0;
      explored_q <= 1'b0;
      episode_q  <= 1'b0;
    end else if (state_q == S_WB) begin
      node_q     <= NODE_W'(chosen_q);
      value_q    <= chosen_ok_c ? VAL_W'(nv_c) : '0;
      explored_q <= explore_q;
      episode_q  <= leaf_q;
    end
  end

  assign done_o         = done_q;
  assign node_o         = node_q;
  assign new_value_o    = value_q;
  assign explored_o     = explored_q;
  assign episode_done_o = episode_q;

  // The walk never rests on a leaf.
  `TQLS_ASSERT_IMP(a_cur_inner, 1'b1, 32'(cur_q) < INNER)
  // A step request always makes the block busy in the next cycle.
  `TQLS_ASSERT_NEXT(a_step_busy, accept && (op_i == OP_STEP), busy)
  // Write-back is always followed by a result.
  `TQLS_ASSERT_NEXT(a_wb_done, state_q == S_WB, done_o)
  // A finished episode leaves the walk at the root.
  `TQLS_ASSERT_IMP(a_done_root, done_o && episode_done_o, cur_q == '0)

endmodule
`default_nettype wire

[test/tree_q_learning_step_tb.sv]
// Self-checking testbench of the tree Q-learning step block: predicted loads and walk steps.
module tree_q_learning_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tqls_pkg::*;

  localparam int INNER_NODES   = (1 << LEVELS_DEF) - 1;
  localparam int VALUE_MAX     = (1 << VALUE_BITS_DEF) - 1;
  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 238;

  typedef struct packed {
    op_e                 op;
    logic [NODE_W-1:0]   index;
    logic [VAL_W-1:0]    value;
    logic [CHANCE_W-1:0] chance;
    logic                coin;
  } request_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [VAL_W-1:0]  new_value;
    logic              explored;
    logic              episode_done;
  } visit_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  start         = 1'b0;
  logic                  busy;
  op_e                   op_i          = OP_LOAD;
  logic [NODE_W-1:0]     entry_index_i = '0;
  logic [VAL_W-1:0]      entry_value_i = '0;
  logic [CHANCE_W-1:0]   chance_i      = '0;
  logic                  coin_i        = 1'b0;
  logic                  done_o;
  logic [NODE_W-1:0]     node_o;
  logic [VAL_W-1:0]      new_value_o;
  logic                  explored_o;
  logic                  episode_done_o;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_index_i   = CFG_ALPHA;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Shadow of the block's registers, table and walk position.
  logic [COEF_W-1:0] alpha_now        = ALPHA_RST;
  logic [COEF_W-1:0] gamma_now        = GAMMA_RST;
  logic [EPS_W-1:0]  epsilon_now      = EPSILON_RST;
  logic [NODE_W-1:0] goal_now         = GOAL_NODE_RST;
  logic [VAL_W-1:0]  goal_reward_now  = GOAL_REWARD_RST;
  logic [NODE_W-1:0] bonus_now        = BONUS_NODE_RST;
  logic [VAL_W-1:0]  bonus_reward_now = BONUS_REWARD_RST;
  logic [VAL_W-1:0]  q_shadow [NODES_DEF];
  int unsigned       walk_node = 0;

  request_t requests_pending [$];
  visit_t   visits_due [$];
  request_t req_shown;
  bit       showing = 1'b0;
  bit       steady = 1'b0;
  int       gap_left = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;

  tree_q_learning_step u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .chance_i       (chance_i),
    .coin_i         (coin_i),
    .done_o         (done_o),
    .node_o         (node_o),
    .new_value_o    (new_value_o),
    .explored_o     (explored_o),
    .episode_done_o (episode_done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned q_at(input int unsigned idx);
    return (idx < NODES_DEF) ? q_shadow[idx] : 0;
  endfunction

  // Moves q toward target by alpha, rounding the step towards minus infinity.
  function automatic int nudge(input int q, input int target);
    int prod;
    int r;
    prod = int'(alpha_now) * (target - q);
    r = q + (prod >>> 8);
    if (r < 0) r = 0;
    if (r > VALUE_MAX) r = VALUE_MAX;
    return r;
  endfunction

  function automatic visit_t learn_step(input request_t r);
    visit_t      v;
    int unsigned left;
    int unsigned pick;
    int unsigned qmax;
    int unsigned target;
    int unsigned nv;
    bit          leaf;
    v = '0;
    if (r.op == OP_LOAD) begin
      if (r.index < NODES_DEF) q_shadow[r.index] = r.value;
      v.node = r.index;
      v.new_value = VAL_W'(q_at(r.index));
    end else begin
      left = 2 * walk_node + 1;
      v.explored = r.chance < epsilon_now;
      if (v.explored) pick = left + r.coin;
      else pick = (q_at(left) > q_at(left + 1)) ? left : left + 1;
      leaf = pick >= INNER_NODES;
      nv = q_at(pick);
      if (!leaf) begin
        qmax = (q_at(2 * pick + 1) > q_at(2 * pick + 2)) ? q_at(2 * pick + 1) : q_at(2 * pick + 2);
        target = (gamma_now * qmax) >> 8;
        if (target > VALUE_MAX) target = VALUE_MAX;
        nv = nudge(nv, target);
      end else if (pick == goal_now) begin
        nv = nudge(nv, goal_reward_now);
      end else if (pick == bonus_now) begin
        nv = nudge(nv, bonus_reward_now);
      end
      if (pick < NODES_DEF) q_shadow[pick] = VAL_W'(nv);
      walk_node = leaf ? 0 : pick;
      v.node = pick[NODE_W-1:0];
      v.new_value = VAL_W'(q_at(pick));
      v.episode_done = leaf;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Request driver: a random gap before each request, with runs of back-to-back requests.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (showing && !busy) begin
        visits_due.push_back(learn_step(req_shown));
        showing = 1'b0;
        gap_left = steady ? 0 : $urandom_range(7, 0);
      end
      if (!showing) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (requests_pending.size() != 0) begin
          req_shown = requests_pending.pop_front();
          op_i <= req_shown.op;
          entry_index_i <= req_shown.index;
          entry_value_i <= req_shown.value;
          chance_i <= req_shown.chance;
          coin_i <= req_shown.coin;
          start <= 1'b1;
          showing = 1'b1;
          if ($urandom_range(31, 0) == 0) steady = !steady;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    visit_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (visits_due.size() == 0) begin
        report_mismatch($sformatf("result at node %0d with no request outstanding", node_o));
      end else begin
        want = visits_due.pop_front();
        if (node_o !== want.node)
          report_mismatch($sformatf("node %0d, expected %0d", node_o, want.node));
        if (new_value_o !== want.new_value)
          report_mismatch($sformatf("node %0d new_value %0d, expected %0d",
                                    want.node, new_value_o, want.new_value));
        if (explored_o !== want.explored)
          report_mismatch($sformatf("node %0d explored %b, expected %b",
                                    want.node, explored_o, want.explored));
        if (episode_done_o !== want.episode_done)
          report_mismatch($sformatf("node %0d episode_done %b, expected %b",
                                    want.node, episode_done_o, want.episode_done));
      end
    end
  end

  // Watchdog: ends the run once nothing has moved on any channel for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o === 1'b1 || (cfg_valid_i && cfg_ready_o === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_load(input int idx, input int value);
    request_t r;
    r.op = OP_LOAD;
    r.index = idx[NODE_W-1:0];
    r.value = value[VAL_W-1:0];
    r.chance = CHANCE_W'($urandom_range(255, 0));
    r.coin = 1'($urandom_range(1, 0));
    requests_pending.push_back(r);
  endtask

  task automatic push_step(input int chance, input int coin);
    request_t r;
    r.op = OP_STEP;
    r.index = NODE_W'($urandom_range(15, 0));
    r.value = VAL_W'($urandom_range(VALUE_MAX, 0));
    r.chance = chance[CHANCE_W-1:0];
    r.coin = coin[0];
    requests_pending.push_back(r);
  endtask

  // Waits until every request has been taken and answered, then lets the block settle.
  task automatic wait_idle();
    while (requests_pending.size() != 0 || start || visits_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ALPHA:        alpha_now = data[COEF_W-1:0];
      CFG_GAMMA:        gamma_now = data[COEF_W-1:0];
      CFG_EPSILON:      epsilon_now = data[EPS_W-1:0];
      CFG_GOAL_NODE:    goal_now = data[NODE_W-1:0];
      CFG_GOAL_REWARD:  goal_reward_now = data[VAL_W-1:0];
      CFG_BONUS_NODE:   bonus_now = data[NODE_W-1:0];
      CFG_BONUS_REWARD: bonus_reward_now = data[VAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int alpha, input int gamma, input int eps, input int goal,
                          input int goal_reward, input int bonus, input int bonus_reward);
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_GAMMA, gamma);
    write_reg(CFG_EPSILON, eps);
    write_reg(CFG_GOAL_NODE, goal);
    write_reg(CFG_GOAL_REWARD, goal_reward);
    write_reg(CFG_BONUS_NODE, bonus);
    write_reg(CFG_BONUS_REWARD, bonus_reward);
  endtask

  // Mostly walk steps with random draws; the odd load keeps the table moving.
  task automatic random_phase();
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(99, 0) < 15)
        push_load($urandom_range(15, 0), $urandom_range(VALUE_MAX, 0));
      else
        push_step($urandom_range(255, 0), $urandom_range(1, 0));
    end
    wait_idle();
  endtask

  initial begin
    // Every entry is loaded before the first step, so no step reads an undefined entry.
    for (int i = 0; i < NODES_DEF; i++)
      push_load(i, (i == 3) ? VALUE_MAX : (i == 1 || i == 2) ? 500 : (i * 67) % 1000);
    push_load(15, VALUE_MAX);
    // Explore down to the goal leaf, then the bonus leaf, then an unrewarded leaf.
    repeat (3) push_step(0, 1);
    push_step(76, 1);
    push_step(76, 0);
    push_step(76, 0);
    repeat (3) push_step(0, 0);
    // Greedy steps from the root, starting where the left child is strictly better.
    push_step(77, 0);
    push_step(255, 1);
    push_step(255, 0);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    set_regs(255, 255, 0, 14, 1000, 11, 500);
    random_phase();
    set_regs(0, 0, 256, 7, 0, 8, 1000);
    random_phase();
    // Goal and bonus on the same leaf: the goal reward must win.
    set_regs(128, 200, 128, 10, 1000, 10, 0);
    random_phase();
    // Reward nodes placed on inner nodes earn nothing.
    set_regs(64, 255, 255, 2, 1000, 5, 777);
    random_phase();
    set_regs($urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(256, 0),
             $urandom_range(14, 7), $urandom_range(1000, 0), $urandom_range(14, 0),
             $urandom_range(1000, 0));
    random_phase();
    set_regs(ALPHA_RST, GAMMA_RST, $urandom_range(256, 0), GOAL_NODE_RST, GOAL_REWARD_RST,
             BONUS_NODE_RST, BONUS_REWARD_RST);
    random_phase();

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
